>>> hw/rtl/bink_header_offset_table_check_assert.svh
// assertion macros used by the header checker's port checks
// depends on nothing; each macro takes a label, clock, reset, antecedent and consequent
`ifndef BINK_HEADER_OFFSET_TABLE_CHECK_ASSERT_SVH
`define BINK_HEADER_OFFSET_TABLE_CHECK_ASSERT_SVH

// same-cycle implication, off while reset is high
`define BHOTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bhotc assertion failed");

// next-cycle implication, off while reset is high
`define BHOTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhotc assertion failed");

`endif

>>> hw/rtl/bhotc_pkg.sv
// types and constants for the bink header and offset table checker
// used by every rtl module of the block; depends on nothing
package bhotc_pkg;

  localparam int LIMIT_W = 33;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;

  // header lengths and range limits
  localparam int HDR_SHORT = 40;
  localparam int HDR_LONG  = 48;
  localparam int HDR_SLACK = 8;
  localparam int MAX_DIM   = 32768;
  localparam int MAX_RATE  = 100000;

  // version codes at byte 3
  localparam logic [BYTE_W-1:0] VER_B = 8'h62;
  localparam logic [BYTE_W-1:0] VER_F = 8'h66;
  localparam logic [BYTE_W-1:0] VER_G = 8'h67;

  // byte positions inside the fixed header
  localparam int POS_VERSION  = 3;
  localparam int POS_FRAMES   = 15;
  localparam int POS_RATE     = 19;
  localparam int POS_HDR_TAIL = 20;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // one input beat
  typedef struct packed {
    logic               kind;
    logic [LIMIT_W-1:0] limit;
    logic [BYTE_W-1:0]  data_byte;
  } beat_t;

  // decision for one processed beat
  typedef struct packed {
    logic              hit;
    logic              ok;
    logic [WORD_W-1:0] total;
  } verdict_t;

endpackage

>>> hw/rtl/bhotc_in_stage.sv
// input register of the header checker: holds one accepted beat
// depends on bhotc_pkg
module bhotc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bhotc_pkg::beat_t  in_beat,
  input  logic              take,
  output logic              held_valid,
  output bhotc_pkg::beat_t  held_beat
);
  import bhotc_pkg::*;

  // free when empty or when the held beat moves on this cycle
  assign in_ready = !held_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
  end

endmodule

>>> hw/rtl/bhotc_core.sv
// candidate state and all header and offset table checks for one beat
// depends on bhotc_pkg
module bhotc_core #(
  parameter int MAX_FRAMES = 1048576
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  bhotc_pkg::beat_t    beat,
  output bhotc_pkg::verdict_t verdict
);
  import bhotc_pkg::*;

  localparam int FC_W  = $clog2(MAX_FRAMES + 1);
  localparam int POS_W = $clog2(HDR_LONG + 4 * (MAX_FRAMES + 1) + 1);

  logic [POS_W-1:0]   position,        position_next;
  logic               active,          active_next;
  logic               long_header,     long_header_next;
  logic [LIMIT_W-1:0] byte_limit,      byte_limit_next;
  logic [WORD_W-1:0]  word_gather,     word_gather_next;
  logic [WORD_W-1:0]  first_offset,    first_offset_next;
  logic [WORD_W-1:0]  previous_offset, previous_offset_next;
  logic [POS_W-1:0]   table_end,       table_end_next;

  logic [WORD_W-1:0] gathered;
  logic [POS_W-1:0]  hdr_cur;
  logic [POS_W-1:0]  hdr_new;
  logic [POS_W-1:0]  frames_plus;
  logic [POS_W-1:0]  table_end_new;
  logic              version_ok;
  logic              last_byte;

  // word with the current byte shifted in from the top
  assign gathered    = {beat.data_byte, word_gather[WORD_W-1:BYTE_W]};
  assign hdr_cur     = long_header ? POS_W'(HDR_LONG) : POS_W'(HDR_SHORT);
  assign version_ok  = (beat.data_byte == VER_B) || (beat.data_byte == VER_F) ||
                       (beat.data_byte == VER_G);
  assign hdr_new     = (beat.data_byte != VER_B) ? POS_W'(HDR_LONG) : POS_W'(HDR_SHORT);
  assign last_byte   = (position[1:0] == 2'b11);

  // table end from the frame count word arriving now
  assign frames_plus   = POS_W'(gathered[FC_W-1:0]) + POS_W'(1);
  assign table_end_new = hdr_cur + (frames_plus << 2);

  // next state and verdict
  always_comb begin
    position_next        = position;
    active_next          = active;
    long_header_next     = long_header;
    byte_limit_next      = byte_limit;
    word_gather_next     = word_gather;
    first_offset_next    = first_offset;
    previous_offset_next = previous_offset;
    table_end_next       = table_end;
    verdict              = '0;

    if (take) begin
      if (beat.kind == KIND_START) begin
        position_next        = '0;
        active_next          = 1'b1;
        long_header_next     = 1'b0;
        byte_limit_next      = beat.limit;
        word_gather_next     = '0;
        first_offset_next    = '0;
        previous_offset_next = '0;
        table_end_next       = '0;
      end else if (active) begin
        position_next    = position + POS_W'(1);
        word_gather_next = gathered;
        if (position < POS_W'(POS_VERSION)) begin
          // signature bytes pass unchecked
        end else if (position == POS_W'(POS_VERSION)) begin
          long_header_next = (beat.data_byte != VER_B);
          if (!version_ok) begin
            verdict.hit = 1'b1;
          end else if (byte_limit < LIMIT_W'(hdr_new + POS_W'(HDR_SLACK))) begin
            verdict.hit = 1'b1;
          end
        end else if (position < POS_W'(POS_HDR_TAIL)) begin
          // fixed header words, checked on their last byte
          if (last_byte) begin
            if (position == POS_W'(POS_FRAMES)) begin
              table_end_next = table_end_new;
              if (gathered == '0 || gathered > WORD_W'(MAX_FRAMES)) begin
                verdict.hit = 1'b1;
              end else if (LIMIT_W'(table_end_new) > byte_limit) begin
                verdict.hit = 1'b1;
              end
            end else if (position == POS_W'(POS_RATE)) begin
              if (gathered == '0 || gathered > WORD_W'(MAX_RATE)) begin
                verdict.hit = 1'b1;
              end
            end else begin
              if (gathered == '0 || gathered > WORD_W'(MAX_DIM)) begin
                verdict.hit = 1'b1;
              end
            end
          end
        end else if (position >= hdr_cur && last_byte) begin
          // offset table entries
          if (position == hdr_cur + POS_W'(3)) begin
            first_offset_next    = gathered;
            previous_offset_next = gathered;
            if (gathered < WORD_W'(table_end)) begin
              verdict.hit = 1'b1;
            end
          end else begin
            previous_offset_next = gathered;
            if (gathered < previous_offset) begin
              verdict.hit = 1'b1;
            end else if (position == table_end - POS_W'(1)) begin
              verdict.hit = 1'b1;
              if (gathered > first_offset && LIMIT_W'(gathered) <= byte_limit) begin
                verdict.ok    = 1'b1;
                verdict.total = gathered;
              end
            end
          end
        end
        if (verdict.hit) begin
          active_next = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      position    <= '0;
      long_header <= 1'b0;
    end else begin
      active      <= active_next;
      position    <= position_next;
      long_header <= long_header_next;
    end
  end

  // candidate payload state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit      <= '0;
      word_gather     <= '0;
      first_offset    <= '0;
      previous_offset <= '0;
      table_end       <= '0;
    end else begin
      byte_limit      <= byte_limit_next;
      word_gather     <= word_gather_next;
      first_offset    <= first_offset_next;
      previous_offset <= previous_offset_next;
      table_end       <= table_end_next;
    end
  end

endmodule

>>> hw/rtl/bhotc_out_stage.sv
// result register of the header checker: holds one verdict beat
// depends on bhotc_pkg
module bhotc_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  bhotc_pkg::verdict_t verdict,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                valid_res,
  output logic [bhotc_pkg::WORD_W-1:0] total_size
);
  import bhotc_pkg::*;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && verdict.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take && verdict.hit) begin
      valid_res  <= verdict.ok;
      total_size <= verdict.total;
    end
  end

endmodule

>>> hw/rtl/bink_header_offset_table_check.sv
// a deciding data byte passes the input register and the single check stage;
// its verdict beat is registered in the result register; throughput: one input
// beat per cycle while the result register is free or draining
// reset: synchronous, clears the open candidate and both register stages;
// no clearing pass, in_ready is high in the first cycle after reset
module bink_header_offset_table_check #(
  parameter int MAX_FRAMES = 1048576
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [bhotc_pkg::LIMIT_W-1:0]  limit,
  input  logic [bhotc_pkg::BYTE_W-1:0]   data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           valid_res,
  output logic [bhotc_pkg::WORD_W-1:0]   total_size
);
  import bhotc_pkg::*;

  beat_t    in_beat;
  beat_t    held_beat;
  logic     held_valid;
  logic     take;
  verdict_t verdict;

  assign in_beat = '{kind: kind, limit: limit, data_byte: data_byte};

  // held beat moves on when the result slot is free or drains this cycle
  assign take = held_valid && (!out_valid || out_ready);

  bhotc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .take       (take),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  bhotc_core #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .beat    (held_beat),
    .verdict (verdict)
  );

  bhotc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .verdict    (verdict),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .total_size (total_size)
  );

endmodule

>>> hw/rtl/bhotc_checker.sv
// port-level checks for the header checker, bound to its top level
// depends on bhotc_pkg and bink_header_offset_table_check_assert.svh
`include "bink_header_offset_table_check_assert.svh"

module bhotc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         valid_res,
  input logic [bhotc_pkg::WORD_W-1:0] total_size
);
  import bhotc_pkg::*;

  // a stalled verdict beat stays
  `BHOTC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // a rejection carries no size
  `BHOTC_ASSERT_IMP(a_reject_zero, clk, rst, out_valid && !valid_res, total_size == '0)

  // a pass size lies beyond the shortest header plus a two entry table
  `BHOTC_ASSERT_IMP(a_pass_size, clk, rst, out_valid && valid_res,
                    total_size > WORD_W'(HDR_SHORT + HDR_SLACK))

  // reset leaves the block empty and ready
  `BHOTC_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !out_valid && in_ready)

endmodule

bind bink_header_offset_table_check bhotc_checker u_bhotc_checker (.*);
